// ===== rtl/ping_round_trip_tracker_core_assert.svh =====
// Assertion macros for the ping round-trip tracker.
`ifndef PING_ROUND_TRIP_TRACKER_CORE_ASSERT_SVH
`define PING_ROUND_TRIP_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define PRTT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define PRTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/prtt_pkg.sv =====
// Shared constants, beat types, command/status structs and helpers of the tracker.
`default_nettype none

package prtt_pkg;

    // block constants
    localparam int MAX_FINAL  = 255;
    localparam int TIME_BITS  = 48;
    localparam int IN_TIME_W  = 48;
    localparam int MEAN_W     = 56;
    localparam int FRAC_BITS  = 8;
    localparam int NUM_W      = TIME_BITS + FRAC_BITS;
    localparam int DCNT_W     = $clog2(NUM_W);

    localparam logic [7:0] MIN_FINAL     = 8'd3;
    localparam logic [7:0] IDX_STEP      = 8'd2;
    localparam logic [7:0] START_MARKER  = 8'hFF;
    localparam logic [7:0] DFLT_FINAL_RST = 8'd10;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_PING  = 1'b1;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // configuration port
    localparam int NUM_REGS   = 2;
    localparam int APB_DATA_W = 64;
    localparam int PADDR_W    = $clog2(8 * NUM_REGS);
    localparam int REG_IDX_W  = PADDR_W - 3;
    localparam logic [REG_IDX_W-1:0] REG_STREAM_ID     = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_DEFAULT_FINAL = REG_IDX_W'(1);

    typedef struct packed {
        logic                 kind;
        logic [7:0]           ping_index;
        logic [7:0]           peer_final;
        logic [IN_TIME_W-1:0] time_now;
    } t_in_beat;

    typedef struct packed {
        logic              status;
        logic              send_ping;
        logic [7:0]        send_index;
        logic [7:0]        send_final;
        logic [63:0]       send_stream;
        logic              done_res;
        logic [MEAN_W-1:0] mean_round_trip;
    } t_out_beat;

    typedef struct packed {
        logic [63:0] stream_id;
        logic [7:0]  default_final;
    } t_cfg;

    typedef struct packed {
        logic eval;      // input beat accepted: evaluate and update exchange
        logic div_step;  // one quotient bit
        logic load;      // move staged result into the output register
    } t_cmd;

    typedef struct packed {
        logic need_div;  // valid with eval
        logic div_last;  // divider on its final bit
    } t_stat;

    // ceil(fin/2)+1, kept to 8 bits
    function automatic logic [7:0] cap_of(input logic [7:0] fin);
        logic [8:0] s;
        s = 9'(fin >> 1) + 9'(fin[0]) + 9'd1;
        return s[7:0];
    endfunction

    // low TIME_BITS bits of the incoming time stamp
    function automatic logic [TIME_BITS-1:0] time_of(input logic [IN_TIME_W-1:0] t);
        logic [63:0] w;
        w = 64'(t);
        return w[TIME_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/prtt_stream_if.sv =====
// Valid/ready channel interfaces for input and result beats.
`default_nettype none

interface prtt_in_if import prtt_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface prtt_out_if import prtt_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/prtt_cfg.sv =====
// APB-style register bank: stream id and default final index.
`default_nettype none

module prtt_cfg import prtt_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_W-1:0]    paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    logic [63:0]          r_stream_id, n_stream_id;
    logic [7:0]           r_default_final, n_default_final;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[PADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        n_stream_id     = r_stream_id;
        n_default_final = r_default_final;
        if (wr_en) begin
            case (reg_idx)
                REG_STREAM_ID: begin
                    n_stream_id = pwdata[63:0];
                end
                REG_DEFAULT_FINAL: begin
                    n_default_final = pwdata[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_id     <= '0;
            r_default_final <= DFLT_FINAL_RST;
        end else begin
            r_stream_id     <= n_stream_id;
            r_default_final <= n_default_final;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_STREAM_ID:     prdata = APB_DATA_W'(r_stream_id);
            REG_DEFAULT_FINAL: prdata = APB_DATA_W'(r_default_final);
            default:           prdata = '0;
        endcase
    end

    assign o_cfg.stream_id     = r_stream_id;
    assign o_cfg.default_final = r_default_final;

endmodule

`default_nettype wire

// ===== rtl/prtt_ctrl.sv =====
// Controller: accept, divide and output-load sequencing, output valid flag.
`default_nettype none

module prtt_ctrl import prtt_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.eval = 1'b1;
                    n_state    = i_stat.need_div ? S_DIV : S_LOAD;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (slot_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/prtt_dpath.sv =====
// Datapath: exchange state, beat evaluation, restoring divider, result registers.
`default_nettype none

module prtt_dpath import prtt_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  t_cmd       i_cmd,
    input  t_cfg       i_cfg,
    input  t_in_beat   i_beat,
    output t_stat      o_stat,
    output t_out_beat  o_out
);

    // exchange state
    logic                 r_active, n_active;
    logic [7:0]           r_cap, n_cap;
    logic [7:0]           r_count, n_count;
    logic                 r_order_bad, n_order_bad;
    logic [TIME_BITS-1:0] r_first, n_first;
    logic [7:0]           r_last_idx, n_last_idx;

    // staged result and divider
    t_out_beat            r_res, n_res;
    t_out_beat            r_out, n_out;
    logic [7:0]           r_rem, n_rem;
    logic [NUM_W-1:0]     r_quo, n_quo;
    logic [7:0]           r_dvsr, n_dvsr;
    logic [DCNT_W-1:0]    r_dcnt, n_dcnt;

    // evaluation terms
    logic [TIME_BITS-1:0] t_now;
    logic [7:0]           idx, fin;
    logic                 fin_bad;
    logic [7:0]           cnt0, cap_e, cnt_new;
    logic                 step_bad, ob_new, full;
    logic [TIME_BITS-1:0] first_new, dt;
    logic [7:0]           dvsr_e;
    logic                 need_div;

    // divider step
    logic [8:0]           rem_sh;
    logic                 ge;
    logic [63:0]          quo_w;
    logic [MEAN_W-1:0]    mean_sat;

    assign t_now   = time_of(i_beat.time_now);
    assign idx     = i_beat.ping_index;
    assign fin     = i_beat.peer_final;
    assign fin_bad = (9'(fin) > 9'(MAX_FINAL)) || (fin < MIN_FINAL) || (fin < idx);

    assign cnt0      = r_active ? r_count : 8'd0;
    assign cap_e     = r_active ? r_cap : cap_of(fin);
    assign cnt_new   = cnt0 + 8'd1;
    assign step_bad  = (cnt0 != 8'd0) && (8'(idx - r_last_idx) != IDX_STEP);
    assign ob_new    = (r_active && r_order_bad) || step_bad;
    assign full      = cnt_new >= cap_e;
    assign first_new = (cnt0 == 8'd0) ? t_now : r_first;
    assign dt        = t_now - first_new;
    assign dvsr_e    = (cap_e > 8'd1) ? 8'(cap_e - 8'd1) : 8'd1;

    assign rem_sh = {r_rem, r_quo[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dvsr};

    assign quo_w    = 64'(r_quo);
    assign mean_sat = (quo_w[63:MEAN_W] != '0) ? {MEAN_W{1'b1}} : quo_w[MEAN_W-1:0];

    always_comb begin
        n_active    = r_active;
        n_cap       = r_cap;
        n_count     = r_count;
        n_order_bad = r_order_bad;
        n_first     = r_first;
        n_last_idx  = r_last_idx;
        n_res       = r_res;
        n_out       = r_out;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_dvsr      = r_dvsr;
        n_dcnt      = r_dcnt;
        need_div    = 1'b0;

        if (i_cmd.eval) begin
            n_res       = '0;
            n_rem       = '0;
            n_quo       = {dt, {FRAC_BITS{1'b0}}};
            n_dvsr      = dvsr_e;
            n_dcnt      = DCNT_W'(NUM_W - 1);
            // any branch that ends the exchange leaves these cleared
            n_active    = 1'b0;
            n_cap       = '0;
            n_count     = '0;
            n_order_bad = 1'b0;

            if (i_beat.kind == KIND_START) begin
                n_active          = 1'b1;
                n_cap             = cap_of(i_cfg.default_final);
                n_count           = 8'd1;
                n_first           = t_now;
                n_last_idx        = START_MARKER;
                n_res.send_ping   = 1'b1;
                n_res.send_index  = 8'd0;
                n_res.send_final  = i_cfg.default_final;
                n_res.send_stream = i_cfg.stream_id;
            end else if (fin_bad) begin
                n_res.status = STATUS_ERR;
            end else if (!r_active && (idx != 8'd0)) begin
                n_res.status = STATUS_ERR;
            end else if (r_active && (r_count >= r_cap)) begin
                n_res.status = STATUS_ERR;
            end else begin
                if (idx != fin) begin
                    n_res.send_ping   = 1'b1;
                    n_res.send_index  = 8'(idx + 8'd1);
                    n_res.send_final  = fin;
                    n_res.send_stream = i_cfg.stream_id;
                end
                if (full) begin
                    if (ob_new) begin
                        n_res.status = STATUS_ERR;
                    end else begin
                        n_res.done_res = 1'b1;
                        need_div       = 1'b1;
                    end
                end else begin
                    n_active    = 1'b1;
                    n_cap       = cap_e;
                    n_count     = cnt_new;
                    n_order_bad = ob_new;
                    n_first     = first_new;
                    n_last_idx  = idx;
                end
            end
        end

        if (i_cmd.div_step) begin
            n_rem  = ge ? 8'(rem_sh - {1'b0, r_dvsr}) : rem_sh[7:0];
            n_quo  = {r_quo[NUM_W-2:0], ge};
            n_dcnt = r_dcnt - DCNT_W'(1);
        end

        if (i_cmd.load) begin
            n_out                 = r_res;
            n_out.mean_round_trip = r_res.done_res ? mean_sat : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_cap       <= '0;
            r_count     <= '0;
            r_order_bad <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_cap       <= n_cap;
            r_count     <= n_count;
            r_order_bad <= n_order_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first    <= n_first;
        r_last_idx <= n_last_idx;
        r_res      <= n_res;
        r_out      <= n_out;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_dvsr     <= n_dvsr;
        r_dcnt     <= n_dcnt;
    end

    assign o_stat.need_div = need_div;
    assign o_stat.div_last = (r_dcnt == '0);
    assign o_out           = r_out;

endmodule

`default_nettype wire

// ===== rtl/ping_round_trip_tracker_core.sv =====
// Top level of the ping round-trip tracker: register bank, controller and datapath.
//
// Follows one alternating ping exchange and gives exactly one result beat per input
// beat. A start beat (kind 0) opens an exchange with a marker entry and requests
// ping 0 using default_final; received pings (kind 1) are checked, recorded, and
// the next index is requested unless the ping was the final one. When the exchange
// holds ceil(final/2)+1 entries the result carries the mean entry spacing with 8
// fraction bits, or status 1 if the indices did not step by 2. Any error clears the
// exchange. Timing: a beat is taken only in idle. A beat that needs no divide (every
// beat but one that completes with a valid mean) goes from idle to the load state,
// which loads its result into the output register and returns to idle, where the
// next beat can be taken. A beat that completes with a valid mean first runs a
// restoring divider by (capacity-1), one quotient bit per cycle over TIME_BITS+8 =
// 56 bits, and then passes through the load state. The load waits while the output
// register still holds a result that is not taken. The output register decouples
// the two sides: the next beat is accepted while a result still waits to be taken.
// Registers sit on the APB-style port at byte 0 (stream_id, 64 bits) and byte 8
// (default_final); writes are expected only while the block is idle.
`default_nettype none

`include "ping_round_trip_tracker_core_assert.svh"

module ping_round_trip_tracker_core import prtt_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    prtt_in_if.sink                    i_in_beat,
    prtt_out_if.source                 o_out_beat,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_W-1:0]    paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    t_cfg      cfg;
    t_cmd      cmd;
    t_stat     stat;
    t_out_beat out_beat;
    logic      in_ready;
    logic      out_valid;

    prtt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencing: idle -> (divide) -> load output register
    prtt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_beat.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out_beat.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // exchange bookkeeping, mean divider, result beat
    prtt_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_cfg   (cfg),
        .i_beat  (i_in_beat.payload),
        .o_stat  (stat),
        .o_out   (out_beat)
    );

    assign i_in_beat.ready    = in_ready;
    assign o_out_beat.valid   = out_valid;
    assign o_out_beat.payload = out_beat;

    // one beat in flight: no accept right after an accept
    `PRTT_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_beat.valid && in_ready, !in_ready, "beat accepted while previous beat still in work")
    // no new beat while the divider runs
    `PRTT_ASSERT_IMPL(a_busy_div, i_clk, i_rst_n, cmd.div_step, !in_ready && !cmd.load, "input open or load during divide")
    // a load always presents a result in the next cycle
    `PRTT_ASSERT_NEXT(a_load_valid, i_clk, i_rst_n, cmd.load, out_valid, "loaded result not presented")
    // a load never overwrites a result that was not taken
    `PRTT_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, cmd.load && out_valid, o_out_beat.ready, "untaken result overwritten")

endmodule

`default_nettype wire
